[hw/rtl/lpu_pkg.sv]
`timescale 1ns / 1ps

package lpu_pkg;

	localparam int ColorW = 24;
	localparam int IndexW = 8;
	localparam int LightW = 17;
	localparam int MagW = 5;
	localparam int ColW = 11;
	localparam int CfgIndexW = 4;
	localparam int CfgDataW = 17;

	localparam logic [ColorW-1:0] GreenMask = 24'h00FF00;

	localparam logic [CfgIndexW-1:0] CfgLightLevel = 4'd0;
	localparam logic [CfgIndexW-1:0] CfgGreenOnly = 4'd1;
	localparam logic [CfgIndexW-1:0] CfgMagnification = 4'd2;
	localparam logic [CfgIndexW-1:0] CfgRowWidth = 4'd3;

	localparam logic ActWrite = 1'b0;
	localparam logic ActPixel = 1'b1;

	typedef struct packed {
		logic              action;
		logic [IndexW-1:0] color_index;
		logic [ColorW-1:0] raw_color;
	} in_t;

	typedef struct packed {
		logic [ColorW-1:0] pixel_color;
		logic              row_end;
		logic              last;
	} out_t;

endpackage

[hw/rtl/lpu_palette.sv]
`timescale 1ns / 1ps

module lpu_palette #(
	parameter int ENTRIES = 256,
	parameter int AW = 8
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [AW-1:0]             waddr,
	input  logic [lpu_pkg::ColorW-1:0] wdata,
	input  logic                      re,
	input  logic [AW-1:0]             raddr,
	output logic [lpu_pkg::ColorW-1:0] rdata
);
	import lpu_pkg::*;

	logic [ColorW-1:0] mem_q [ENTRIES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[hw/rtl/lpu_shade.sv]
`timescale 1ns / 1ps

module lpu_shade (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       valid_i,
	output logic                       ready_o,
	input  logic [lpu_pkg::ColorW-1:0] raw_i,
	input  logic [lpu_pkg::LightW-1:0] light_level,
	input  logic                       green_only,
	output logic                       valid_s2,
	input  logic                       ready_i,
	output logic [lpu_pkg::ColorW-1:0] color_s2
);
	import lpu_pkg::*;

	localparam int ProdW = 8 + LightW;

	logic [ProdW-1:0] prod_b, prod_g, prod_r;
	logic [ColorW-1:0] lit;

	assign prod_b = ProdW'(raw_i[7:0]) * ProdW'(light_level);
	assign prod_g = ProdW'(raw_i[15:8]) * ProdW'(light_level);
	assign prod_r = ProdW'(raw_i[23:16]) * ProdW'(light_level);

	always_comb begin
		lit = {prod_r[23:16], prod_g[23:16], prod_b[23:16]};
		if (green_only) begin
			lit = lit & GreenMask;
		end
	end

	assign ready_o = !valid_s2 || ready_i;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_o) begin
			valid_s2 <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_o && valid_i) begin
			color_s2 <= lit;
		end
	end

endmodule

[hw/rtl/lpu_emit.sv]
`timescale 1ns / 1ps

module lpu_emit #(
	parameter int MAX_ROW_WIDTH = 1024,
	parameter int MAX_MAGNIFICATION = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       valid_i,
	output logic                       ready_o,
	input  logic [lpu_pkg::ColorW-1:0] color_i,
	input  logic [lpu_pkg::MagW-1:0]   magnification,
	input  logic [lpu_pkg::ColW-1:0]   row_width,
	output logic                       out_valid,
	input  logic                       out_ready,
	output lpu_pkg::out_t              out_data
);
	import lpu_pkg::*;

	localparam int MagCap = (MAX_MAGNIFICATION > 31) ? 31 : MAX_MAGNIFICATION;
	localparam int RwCap = (MAX_ROW_WIDTH > 2047) ? 2047 : MAX_ROW_WIDTH;

	logic              busy_q;
	logic [ColorW-1:0] color_q;
	logic [MagW-1:0]   rem_q;
	logic [ColW-1:0]   column_q;

	logic [MagW-1:0] mag_eff;
	logic [ColW-1:0] width_eff;
	logic [ColW-1:0] next_col;
	logic            end_row;
	logic            step_last;
	logic            step;
	logic            load;

	always_comb begin
		mag_eff = magnification;
		if (mag_eff == '0) begin
			mag_eff = MagW'(1);
		end
		if (mag_eff > MagW'(MagCap)) begin
			mag_eff = MagW'(MagCap);
		end
		width_eff = row_width;
		if (width_eff == '0) begin
			width_eff = ColW'(1);
		end
		if (width_eff > ColW'(RwCap)) begin
			width_eff = ColW'(RwCap);
		end
	end

	assign next_col = column_q + ColW'(1);
	assign end_row = next_col >= width_eff;
	assign step_last = end_row || (rem_q == '0);
	assign step = busy_q && (!out_valid || out_ready);
	assign ready_o = !busy_q || (step && step_last);
	assign load = valid_i && ready_o;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			column_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (step) begin
				out_valid <= 1'b1;
				column_q <= end_row ? '0 : next_col;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			if (load) begin
				busy_q <= 1'b1;
			end else if (step && step_last) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			color_q <= color_i;
			rem_q <= mag_eff - MagW'(1);
		end else if (step) begin
			rem_q <= rem_q - MagW'(1);
		end
		if (step) begin
			out_data.pixel_color <= color_q;
			out_data.row_end <= end_row;
			out_data.last <= step_last;
		end
	end

endmodule

[hw/rtl/lit_palette_pixel_upscaler_top.sv]
`timescale 1ns / 1ps
// Channel | Direction | Handshake           | Payload
// in      | input     | in_valid/in_ready   | in_data (action, color_index, raw_color)
// out     | output    | out_valid/out_ready | out_data (pixel_color, row_end, last)
// cfg     | input     | cfg_we              | cfg_index, cfg_data
//
// One output pixel per cycle while out_ready is high and the pipeline is fed;
// a source pixel gives up to magnification transactions (at least one), so
// input waits while the emitter repeats a pixel. Palette writes only write the
// palette. From input to first output a pixel is registered in the palette read,
// lighting, emitter and output register stages. Reset clears valids and the
// column counter and loads the config defaults; the palette is undefined until written. Output
// stalls back up through the emitter, lighting and palette read stages.

module lit_palette_pixel_upscaler_top #(
	parameter int PALETTE_ENTRIES = 256,
	parameter int MAX_ROW_WIDTH = 1024,
	parameter int MAX_MAGNIFICATION = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  lpu_pkg::in_t                  in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output lpu_pkg::out_t                 out_data,
	input  logic                          cfg_we,
	input  logic [lpu_pkg::CfgIndexW-1:0] cfg_index,
	input  logic [lpu_pkg::CfgDataW-1:0]  cfg_data
);
	import lpu_pkg::*;

	localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

	logic [LightW-1:0] light_level_q;
	logic              green_only_q;
	logic [MagW-1:0]   magnification_q;
	logic [ColW-1:0]   row_width_q;

	logic              valid_s1;
	logic              hit_s1;
	logic              shade_ready;
	logic              accept;
	logic              hit;
	logic [ColorW-1:0] rdata;
	logic [ColorW-1:0] raw_s1;
	logic              valid_s2;
	logic              emit_ready;
	logic [ColorW-1:0] color_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			light_level_q <= LightW'(65536);
			green_only_q <= 1'b0;
			magnification_q <= MagW'(1);
			row_width_q <= ColW'(256);
		end else if (cfg_we) begin
			case (cfg_index)
				CfgLightLevel:    light_level_q <= cfg_data[LightW-1:0];
				CfgGreenOnly:     green_only_q <= cfg_data[0];
				CfgMagnification: magnification_q <= cfg_data[MagW-1:0];
				CfgRowWidth:      row_width_q <= cfg_data[ColW-1:0];
				default: ;
			endcase
		end
	end

	assign in_ready = !valid_s1 || shade_ready;
	assign accept = in_valid && in_ready;
	assign hit = 32'(in_data.color_index) < PALETTE_ENTRIES;

	lpu_palette #(
		.ENTRIES(PALETTE_ENTRIES),
		.AW(AW)
	) u_palette (
		.clk(clk),
		.we(accept && (in_data.action == ActWrite) && hit),
		.waddr(in_data.color_index[AW-1:0]),
		.wdata(in_data.raw_color),
		.re(accept && (in_data.action == ActPixel)),
		.raddr(in_data.color_index[AW-1:0]),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept && (in_data.action == ActPixel)) begin
			valid_s1 <= 1'b1;
		end else if (shade_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (in_data.action == ActPixel)) begin
			hit_s1 <= hit;
		end
	end

	assign raw_s1 = hit_s1 ? rdata : '0;

	lpu_shade u_shade (
		.clk(clk),
		.arst_n(arst_n),
		.valid_i(valid_s1),
		.ready_o(shade_ready),
		.raw_i(raw_s1),
		.light_level(light_level_q),
		.green_only(green_only_q),
		.valid_s2(valid_s2),
		.ready_i(emit_ready),
		.color_s2(color_s2)
	);

	lpu_emit #(
		.MAX_ROW_WIDTH(MAX_ROW_WIDTH),
		.MAX_MAGNIFICATION(MAX_MAGNIFICATION)
	) u_emit (
		.clk(clk),
		.arst_n(arst_n),
		.valid_i(valid_s2),
		.ready_o(emit_ready),
		.color_i(color_s2),
		.magnification(magnification_q),
		.row_width(row_width_q),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps

import lpu_pkg::*;

class upscale_board;
	localparam int MaxMag = 16;
	localparam int MaxRow = 1024;
	localparam int ProdW = IndexW + LightW;

	logic [ColorW-1:0] palette [256];
	logic [ColW-1:0]   column;
	logic [LightW-1:0] gain;
	logic              green;
	logic [MagW-1:0]   mag;
	logic [ColW-1:0]   width;
	out_t              pixels_due [$];
	int                errors;

	function new();
		column = '0;
		gain = 17'd65536;
		green = 1'b0;
		mag = 5'd1;
		width = 11'd256;
		errors = 0;
	endfunction

	function void set_reg(logic [CfgIndexW-1:0] idx, logic [CfgDataW-1:0] data);
		case (idx)
			CfgLightLevel: gain = data[LightW-1:0];
			CfgGreenOnly: green = data[0];
			CfgMagnification: mag = data[MagW-1:0];
			CfgRowWidth: width = data[ColW-1:0];
			default: ;
		endcase
	endfunction

	function logic [7:0] lit(logic [7:0] c);
		logic [ProdW-1:0] prod;
		prod = ProdW'(c) * ProdW'(gain);
		return prod[23:16];
	endfunction

	function void take_item(in_t t);
		logic [MagW-1:0]   reps;
		logic [ColW-1:0]   span;
		logic [ColorW-1:0] raw;
		logic [ColorW-1:0] shade;
		out_t              o;
		if (t.action == ActWrite) begin
			palette[t.color_index] = t.raw_color;
			return;
		end
		if (mag == 0)
			reps = MagW'(1);
		else if (mag > MaxMag)
			reps = MagW'(MaxMag);
		else
			reps = mag;
		if (width == 0)
			span = ColW'(1);
		else if (width > MaxRow)
			span = ColW'(MaxRow);
		else
			span = width;
		raw = palette[t.color_index];
		shade = {lit(raw[23:16]), lit(raw[15:8]), lit(raw[7:0])};
		if (green)
			shade = shade & GreenMask;
		for (int k = 0; k < reps; k++) begin
			column = column + 1'b1;
			o.pixel_color = shade;
			o.row_end = column >= span;
			o.last = o.row_end || k == reps - 1;
			pixels_due.push_back(o);
			if (o.row_end) begin
				column = '0;
				break;
			end
		end
	endfunction

	task report(string what);
		$display("%0t mismatch: %s", $time, what);
		errors++;
	endtask

	task check_pixel(out_t got);
		out_t want;
		if (pixels_due.size() == 0) begin
			report($sformatf("unexpected transaction, colour %h", got.pixel_color));
			return;
		end
		want = pixels_due.pop_front();
		if (got.pixel_color !== want.pixel_color)
			report($sformatf("colour %h, want %h", got.pixel_color, want.pixel_color));
		if (got.row_end !== want.row_end)
			report($sformatf("row_end %b, want %b", got.row_end, want.row_end));
		if (got.last !== want.last)
			report($sformatf("last %b, want %b", got.last, want.last));
	endtask

	function int due();
		return pixels_due.size();
	endfunction
endclass

module tb_top;
	localparam int Limit = 1000;
	localparam int FirstUnusedReg = int'(CfgRowWidth) + 1;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	in_t                  in_data;
	logic                 out_valid;
	logic                 out_ready;
	out_t                 out_data;
	logic                 cfg_we;
	logic [CfgIndexW-1:0] cfg_index;
	logic [CfgDataW-1:0]  cfg_data;

	logic                 steady;
	int                   hold;
	int                   idle_cycles;
	upscale_board         board;
	int                   stocked [$];
	bit                   stocked_map [256];

	lit_palette_pixel_upscaler_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold <= 0;
		end else if (steady) begin
			out_ready <= 1'b1;
		end else if (hold != 0) begin
			hold <= hold - 1;
		end else begin
			out_ready <= $urandom_range(0, 2) != 0;
			hold <= pick_gap();
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_pixel(out_data);
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= Limit) begin
			$display("== FAIL ==");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function in_t palette_write(int idx, int raw);
		in_t t;
		t.action = ActWrite;
		t.color_index = 8'(idx);
		t.raw_color = 24'(raw);
		return t;
	endfunction

	function in_t source_pixel(int idx);
		in_t t;
		t.action = ActPixel;
		t.color_index = 8'(idx);
		t.raw_color = 24'($urandom);
		return t;
	endfunction

	function in_t random_item();
		if ($urandom_range(0, 99) < 25)
			return palette_write($urandom_range(0, 255), $urandom);
		return source_pixel(stocked[$urandom_range(0, stocked.size() - 1)]);
	endfunction

	task send(in_t t);
		int gap;
		gap = steady ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= t;
		do @(posedge clk); while (!in_ready);
		board.take_item(t);
		if (t.action == ActWrite && !stocked_map[t.color_index]) begin
			stocked_map[t.color_index] = 1'b1;
			stocked.push_back(int'(t.color_index));
		end
	endtask

	task settle();
		in_valid <= 1'b0;
		while (board.due() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task write_reg(logic [CfgIndexW-1:0] idx, logic [CfgDataW-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		board.set_reg(idx, data);
	endtask

	task set_mode(int light, int green_mode, int mag, int width);
		settle();
		write_reg(CfgLightLevel, 17'(light));
		write_reg(CfgGreenOnly, {16'($urandom_range(0, 65535)), 1'(green_mode)});
		write_reg(CfgMagnification, {12'($urandom_range(0, 4095)), 5'(mag)});
		write_reg(CfgRowWidth, {6'($urandom_range(0, 63)), 11'(width)});
		write_reg(CfgIndexW'(FirstUnusedReg + $urandom_range(0, 11)), 17'($urandom));
		cfg_we <= 1'b0;
	endtask

	initial begin
		int light;
		int mag;
		int width;
		board = new();
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		steady <= 1'b1;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(palette_write(8'h00, 24'hFFFFFF));
		send(palette_write(8'hFF, 24'h000000));
		send(palette_write(8'h55, 24'hAAAAAA));
		send(palette_write(8'hAA, 24'h123456));
		send(source_pixel(8'h00));
		send(source_pixel(8'hFF));
		send(source_pixel(8'h55));
		send(source_pixel(8'hAA));
		send(palette_write(8'h55, 24'h00FF80));
		send(source_pixel(8'h55));

		set_mode(131071, 1, 31, 0);
		send(source_pixel(8'h00));
		send(source_pixel(8'hAA));
		send(source_pixel(8'hFF));

		set_mode(0, 0, 0, 2047);
		send(source_pixel(8'h00));
		send(source_pixel(8'h55));

		set_mode(32768, 0, 16, 1024);
		send(source_pixel(8'hAA));
		send(source_pixel(8'h00));
		send(source_pixel(8'h55));
		send(source_pixel(8'hFF));

		set_mode(65536, 1, 3, 5);
		send(source_pixel(8'h00));
		send(source_pixel(8'hAA));

		for (int p = 0; p < 8; p++) begin
			light = p == 0 ? 131071 : p == 1 ? 0 : p == 2 ? 65536 : $urandom_range(0, 131071);
			mag = p == 3 ? 16 : p == 4 ? 0 : p == 5 ? 31 : $urandom_range(1, 4);
			width = p == 6 ? 2047 : p == 7 ? 0 : p == 3 ? 1024 : $urandom_range(1, 48);
			set_mode(light, p % 2, mag, width);
			steady <= p % 3 == 2;
			for (int i = 0; i < 45; i++) begin
				if (i == 22)
					settle();
				send(random_item());
			end
		end

		settle();
		if (board.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule

[sim.f]
hw/rtl/lpu_pkg.sv
hw/rtl/lpu_palette.sv
hw/rtl/lpu_shade.sv
hw/rtl/lpu_emit.sv
hw/rtl/lit_palette_pixel_upscaler_top.sv
bench/tb_top.sv
